FILE: rtl/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg: shared types and constants of the decimal counter display
// Digit count, lockout defaults, register indexes, the result record and
// the seven-segment decode table.
// ----------------------------------------------------------------------------
package dcd_pkg;

  // number of BCD digit cells in the counter chain
  localparam int NUM_DIGITS = 4;

  // scan pointer and digits-in-use widths follow the digit count
  localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int POS_W  = SCAN_W + 1;
  localparam int USED_W = $clog2(NUM_DIGITS + 1);
  localparam logic [USED_W-1:0] USED_RESET =
    USED_W'((NUM_DIGITS < 4) ? NUM_DIGITS : 4);

  // fixed field widths
  localparam int MS_W      = 32;
  localparam int LOCK_W    = 16;
  localparam int SEG_W     = 7;
  localparam int EN_W      = 4;
  localparam int COUNT_W   = 14;
  localparam int SHOWN_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [MS_W-1:0]   MS_MAX         = '1;
  localparam logic [LOCK_W-1:0] RST_LOCK_RESET = 16'd50;
  localparam logic [LOCK_W-1:0] CNT_LOCK_RESET = 16'd150;
  localparam logic [SEG_W-1:0]  SEG_BLANK      = 7'h7F;

  // item kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOCKOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LOCKOUT = 2'd1;

  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic [EN_W-1:0]    digit_enable;
    logic [COUNT_W-1:0] count_value;
    logic [SHOWN_W-1:0] shown_digits;
  } dcd_result_t;

  // active-low common-anode decode, codes above nine fold back modulo ten
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0, 4'd10: s = 7'h40;
      4'd1, 4'd11: s = 7'h79;
      4'd2, 4'd12: s = 7'h24;
      4'd3, 4'd13: s = 7'h30;
      4'd4, 4'd14: s = 7'h19;
      4'd5, 4'd15: s = 7'h12;
      4'd6:        s = 7'h02;
      4'd7:        s = 7'h78;
      4'd8:        s = 7'h00;
      4'd9:        s = 7'h10;
      default:     s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/dcd_channels.sv
// ----------------------------------------------------------------------------
// dcd_channels: valid/ready channels of the decimal counter display
// Input items, result items and the configuration write channel.
// ----------------------------------------------------------------------------
interface dcd_in_if;
  logic valid;
  logic ready;
  logic op;
  logic reset_pressed;
  logic count_pressed;

  modport source (output valid, op, reset_pressed, count_pressed, input ready);
  modport sink   (input valid, op, reset_pressed, count_pressed, output ready);
endinterface

interface dcd_out_if import dcd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SEG_W-1:0]   segments;
  logic [EN_W-1:0]    digit_enable;
  logic [COUNT_W-1:0] count_value;
  logic [SHOWN_W-1:0] shown_digits;

  modport source (output valid, segments, digit_enable, count_value, shown_digits,
                  input ready);
  modport sink   (input valid, segments, digit_enable, count_value, shown_digits,
                  output ready);
endinterface

interface dcd_cfg_if import dcd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LOCK_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/debounced_decimal_counter_display.sv
// ----------------------------------------------------------------------------
// debounced_decimal_counter_display: lockout-filtered BCD push counter
// with a multiplexed four-digit seven-segment scan.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per item, op = tick (1 ms) or button event with the
//            reset and count button levels.
//   out_ch : one result per request: held segment pattern and digit enable,
//            the count as a binary value and the number of scanned digits.
//   cfg_ch : writes the reset and count lockout times (ms); always ready,
//            writes to other indexes are dropped. Write only while idle.
// Throughput: one request per cycle, back to back unless stalled. The digit
//   cells update in the cycle of acceptance; the carry ripples through the
//   cell chain and the lockout check is one 33-bit add and compare, both
//   within that cycle. Each result is registered in the output buffer.
// Stall: a two-entry output buffer keeps accepting while one result waits;
//   in_ch.ready drops only when both entries are full.
// Reset (rst_n low, synchronous): count zero, four digits scanned, display
//   blank, clock and last-accept time zero, lockouts 50 ms and 150 ms.
// ----------------------------------------------------------------------------
module debounced_decimal_counter_display import dcd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  dcd_in_if.sink   in_ch,
  dcd_out_if.source out_ch,
  dcd_cfg_if.sink  cfg_ch
);

  logic [LOCK_W-1:0]  rst_lock_r, cnt_lock_r;
  logic [MS_W-1:0]    ms_r, last_r;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [SCAN_W-1:0]  scan_r;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic [EN_W-1:0]    en_r, en_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic        fire, is_tick, is_event;
  logic        rst_pass, cnt_pass, rst_hit, cnt_hit;
  logic        in_ready;
  logic [SCAN_W-1:0] pos;
  logic [POS_W-1:0]  pos_next;
  logic [USED_W-1:0] used_inc;
  dcd_result_t       result;
  dcd_result_t       out_data;

  logic [3:0] digit     [NUM_DIGITS];
  logic [3:0] digit_nxt [NUM_DIGITS];
  logic       carry     [NUM_DIGITS+1];

  assign fire     = in_ch.valid && in_ready;
  assign is_tick  = (in_ch.op == OP_TICK);
  assign is_event = (in_ch.op == OP_EVENT);
  assign in_ch.ready = in_ready;

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_lock_r <= RST_LOCK_RESET;
      cnt_lock_r <= CNT_LOCK_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_RESET_LOCKOUT) rst_lock_r <= cfg_ch.data;
      if (cfg_ch.index == CFG_COUNT_LOCKOUT) cnt_lock_r <= cfg_ch.data;
    end
  end

  // lockout checks at full width, reset press takes priority
  assign rst_pass = {1'b0, ms_r} > ({1'b0, last_r} + {17'd0, rst_lock_r});
  assign cnt_pass = {1'b0, ms_r} > ({1'b0, last_r} + {17'd0, cnt_lock_r});
  assign rst_hit  = fire && is_event && in_ch.reset_pressed && rst_pass;
  assign cnt_hit  = fire && is_event && !rst_hit && in_ch.count_pressed && cnt_pass;

  // BCD cell chain, carry enters at the units digit
  assign carry[0] = cnt_hit;
  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    dcd_digit_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (rst_hit),
      .carry_in  (carry[g]),
      .carry_out (carry[g+1]),
      .digit     (digit[g]),
      .digit_nxt (digit_nxt[g])
    );
  end

  // digits in use after an increment: highest nonzero digit, at least one
  always_comb begin
    used_inc = USED_W'(1);
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (digit_nxt[k] != 4'd0) used_inc = USED_W'(k + 1);
    end
  end

  // scan step: show current position, then advance or wrap to units
  always_comb begin
    pos      = (POS_W'(scan_r) >= POS_W'(NUM_DIGITS)) ? '0 : scan_r;
    pos_next = POS_W'(pos) + POS_W'(1);
    if (pos_next >= POS_W'(NUM_DIGITS) || pos_next >= POS_W'(used_r)) begin
      pos_next = '0;
    end
  end

  // next held display and counter state
  always_comb begin
    seg_nxt   = seg_r;
    en_nxt    = en_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    if (fire && is_tick) begin
      seg_nxt = seg_lookup(digit[pos]);
      for (int k = 0; k < EN_W; k++) begin
        en_nxt[k] = (k < NUM_DIGITS) && (POS_W'(pos) == POS_W'(k));
      end
    end
    if (rst_hit) begin
      count_nxt = '0;
      used_nxt  = USED_W'(1);
    end else if (cnt_hit) begin
      count_nxt = carry[NUM_DIGITS] ? '0 : count_r + COUNT_W'(1);
      used_nxt  = used_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r    <= '0;
      last_r  <= '0;
      used_r  <= USED_RESET;
      scan_r  <= '0;
      seg_r   <= SEG_BLANK;
      en_r    <= '0;
      count_r <= '0;
    end else begin
      if (fire && is_tick) begin
        if (ms_r != MS_MAX) ms_r <= ms_r + MS_W'(1);
        scan_r <= pos_next[SCAN_W-1:0];
      end
      if (rst_hit || cnt_hit) last_r <= ms_r;
      used_r  <= used_nxt;
      seg_r   <= seg_nxt;
      en_r    <= en_nxt;
      count_r <= count_nxt;
    end
  end

  // result reflects the state after the request
  always_comb begin
    result.segments     = seg_nxt;
    result.digit_enable = en_nxt;
    result.count_value  = count_nxt;
    result.shown_digits = SHOWN_W'(used_nxt);
  end

  dcd_out_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fire),
    .push_ready (in_ready),
    .push_data  (result),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_data)
  );

  assign out_ch.segments     = out_data.segments;
  assign out_ch.digit_enable = out_data.digit_enable;
  assign out_ch.count_value  = out_data.count_value;
  assign out_ch.shown_digits = out_data.shown_digits;

  // checks
  a_ms_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ms_r >= $past(ms_r))
    else $error("millisecond clock went backwards");

  a_last_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    last_r <= ms_r)
    else $error("last accept time ahead of clock");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r != '0 && POS_W'(used_r) <= POS_W'(NUM_DIGITS))
    else $error("digits in use out of range");

  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_ch.valid)
    else $error("input stalled with no pending result");

endmodule

FILE: rtl/dcd_digit_cell.sv
// ----------------------------------------------------------------------------
// dcd_digit_cell: one BCD digit of the counter chain
// Holds a decimal digit, takes a carry from the lower neighbor and passes a
// carry up when it rolls over from nine.
// ----------------------------------------------------------------------------
module dcd_digit_cell import dcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clear,
  input  logic       carry_in,
  output logic       carry_out,
  output logic [3:0] digit,
  output logic [3:0] digit_nxt
);

  logic [3:0] digit_r;

  // rollover at nine, clear wins over carry
  always_comb begin
    digit_nxt = digit_r;
    if (clear) begin
      digit_nxt = 4'd0;
    end else if (carry_in) begin
      digit_nxt = (digit_r >= 4'd9) ? 4'd0 : digit_r + 4'd1;
    end
  end

  assign carry_out = carry_in && (digit_r >= 4'd9);
  assign digit     = digit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= 4'd0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

FILE: rtl/dcd_out_skid.sv
// ----------------------------------------------------------------------------
// dcd_out_skid: two-entry result buffer
// Output register plus a skid stage so a new request is taken while the
// previous result still waits on a stalled receiver.
// ----------------------------------------------------------------------------
module dcd_out_skid import dcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  dcd_result_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output dcd_result_t pop_data
);

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  dcd_result_t out_data_r, out_data_nxt;
  dcd_result_t skid_data_r, skid_data_nxt;
  logic        push, pop;

  assign push_ready = !skid_valid_r;
  assign push       = push_valid && push_ready;
  assign pop        = out_valid_r && pop_ready;

  // refill the output from the skid stage first, then from a new request
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_data_nxt   = push_data;
      end else begin
        out_valid_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_data_nxt   = push_data;
        out_valid_nxt  = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign pop_valid = out_valid_r;
  assign pop_data  = out_data_r;

endmodule

FILE: tb/sv/dcd_display_checker.sv
// ----------------------------------------------------------------------------
// dcd_display_checker: result predictor and comparator for the counter display
// Watches the input, result and configuration channels. Every accepted request
// is run through a local model of the lockout filter, the BCD chain and the
// digit scan. Each accepted result is compared field by field against the
// oldest prediction. The failure count and the number of results still owed
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module dcd_display_checker import dcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_op,
  input  logic                 in_reset_pressed,
  input  logic                 in_count_pressed,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [SEG_W-1:0]     out_segments,
  input  logic [EN_W-1:0]      out_digit_enable,
  input  logic [COUNT_W-1:0]   out_count_value,
  input  logic [SHOWN_W-1:0]   out_shown_digits,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LOCK_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // model state, touched only by the monitor process below
  logic [MS_W-1:0]   clock_ms;
  logic [MS_W-1:0]   accept_ms;
  logic [3:0]        digit_cell [NUM_DIGITS];
  logic [USED_W-1:0] used_digits;
  logic [SCAN_W-1:0] scan_ptr;
  logic [SEG_W-1:0]  shown_seg;
  logic [EN_W-1:0]   shown_en;
  logic [LOCK_W-1:0] reset_hold_ms;
  logic [LOCK_W-1:0] count_hold_ms;

  dcd_result_t display_expected [$];
  dcd_result_t predicted;
  dcd_result_t oldest;
  int          errors_seen = 0;

  // active-low glyphs, A in bit 0 .. G in bit 6
  function automatic logic [SEG_W-1:0] glyph_of(input logic [3:0] d);
    case (d % 10)
      0: return 7'b1000000;
      1: return 7'b1111001;
      2: return 7'b0100100;
      3: return 7'b0110000;
      4: return 7'b0011001;
      5: return 7'b0010010;
      6: return 7'b0000010;
      7: return 7'b1111000;
      8: return 7'b0000000;
      default: return 7'b0010000;
    endcase
  endfunction

  // lockout test at 33 bits so the sum never wraps
  function automatic logic lockout_over(input logic [LOCK_W-1:0] hold);
    return {1'b0, clock_ms} > ({1'b0, accept_ms} + {{(MS_W + 1 - LOCK_W){1'b0}}, hold});
  endfunction

  // advance the model by one request and build the result it causes
  task automatic predict_display(input logic op, input logic rst_btn, input logic cnt_btn,
                                 output dcd_result_t res);
    int   pos;
    int   nxt;
    int   k;
    int   value;
    logic carry_done;
    if (op == OP_TICK) begin
      if (clock_ms != MS_MAX) clock_ms = clock_ms + 1;
      pos = scan_ptr;
      if (pos >= NUM_DIGITS) pos = 0;
      shown_seg = glyph_of(digit_cell[pos]);
      shown_en  = EN_W'((1 << pos) & 4'hF);
      nxt = pos + 1;
      if (nxt >= NUM_DIGITS || nxt >= used_digits) nxt = 0;
      scan_ptr = SCAN_W'(nxt);
    end else if (rst_btn && lockout_over(reset_hold_ms)) begin
      for (k = 0; k < NUM_DIGITS; k++) digit_cell[k] = 4'd0;
      used_digits = USED_W'(1);
      accept_ms   = clock_ms;
    end else if (cnt_btn && lockout_over(count_hold_ms)) begin
      // ripple increment, nines roll over to zero
      carry_done = 1'b0;
      for (k = 0; k < NUM_DIGITS; k++) begin
        if (!carry_done) begin
          if (digit_cell[k] >= 4'd9) begin
            digit_cell[k] = 4'd0;
          end else begin
            digit_cell[k] = digit_cell[k] + 4'd1;
            carry_done    = 1'b1;
          end
        end
      end
      used_digits = USED_W'(1);
      for (k = 0; k < NUM_DIGITS; k++)
        if (digit_cell[k] != 4'd0) used_digits = USED_W'(k + 1);
      accept_ms = clock_ms;
    end
    value = 0;
    for (k = NUM_DIGITS - 1; k >= 0; k--) value = value * 10 + (digit_cell[k] % 10);
    res.segments     = shown_seg;
    res.digit_enable = shown_en;
    res.count_value  = COUNT_W'(value);
    res.shown_digits = SHOWN_W'(used_digits);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors_seen++;
    end
  endtask

  // monitor: retire results first, then take config writes and new requests
  always @(posedge clk) begin
    if (!rst_n) begin
      clock_ms      = '0;
      accept_ms     = '0;
      for (int k = 0; k < NUM_DIGITS; k++) digit_cell[k] = 4'd0;
      used_digits   = USED_RESET;
      scan_ptr      = '0;
      shown_seg     = SEG_BLANK;
      shown_en      = '0;
      reset_hold_ms = RST_LOCK_RESET;
      count_hold_ms = CNT_LOCK_RESET;
      display_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (display_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none actual seg=%0d en=%0d count=%0d shown=%0d",
                   $time, out_segments, out_digit_enable, out_count_value, out_shown_digits);
          errors_seen++;
        end else begin
          oldest = display_expected.pop_front();
          check_field("segments", oldest.segments, out_segments);
          check_field("digit_enable", oldest.digit_enable, out_digit_enable);
          check_field("count_value", oldest.count_value, out_count_value);
          check_field("shown_digits", oldest.shown_digits, out_shown_digits);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESET_LOCKOUT: reset_hold_ms = cfg_data;
          CFG_COUNT_LOCKOUT: count_hold_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_display(in_op, in_reset_pressed, in_count_pressed, predicted);
        display_expected.push_back(predicted);
      end
    end
    mismatch_count <= errors_seen;
    results_owed   <= display_expected.size();
  end

endmodule

FILE: tb/sv/debounced_decimal_counter_display_tb.sv
// ----------------------------------------------------------------------------
// debounced_decimal_counter_display_tb: stimulus and verdict for the display
// Drives ticks and button events with random gaps on both sides, walks the
// lockout registers through their extremes, counts through the carries into
// the tens and hundreds digits, probes the lockout boundary and holds the
// result side off long enough to stall the input. The checker beside the
// block predicts and compares; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module debounced_decimal_counter_display_tb import dcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int GAP_MAX     = 11;
  localparam int LONG_HOLD   = 80;
  localparam int LOCK_MAX    = 65535;
  localparam int BOUND_LOCK  = 20;
  localparam int COUNT_RUN   = 110;

  // indexes that map to no register, the block drops such writes
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int mismatch_count;
  int results_owed;
  int cycle_count = 0;
  int gap_max     = GAP_MAX;
  int stall_req   = 0;
  int stall_seen  = 0;

  dcd_in_if  in_ch ();
  dcd_out_if out_ch ();
  dcd_cfg_if cfg_ch ();

  debounced_decimal_counter_display DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dcd_display_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_op            (in_ch.op),
    .in_reset_pressed (in_ch.reset_pressed),
    .in_count_pressed (in_ch.count_pressed),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_segments     (out_ch.segments),
    .out_digit_enable (out_ch.digit_enable),
    .out_count_value  (out_ch.count_value),
    .out_shown_digits (out_ch.shown_digits),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .mismatch_count   (mismatch_count),
    .results_owed     (results_owed)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one request on the input channel, after a random gap
  task automatic push_item(input logic op, input logic rst_btn, input logic cnt_btn);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.reset_pressed <= rst_btn;
    in_ch.count_pressed <= cnt_btn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // ticks ignore the button levels, so those bits are left random
  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_item(OP_TICK, 1'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LOCK_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mostly ticks and count presses, with occasional resets
  task automatic random_items(input int n);
    logic is_event;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_max = 0;
          1: gap_max = 3;
          default: gap_max = GAP_MAX;
        endcase
      end
      is_event = ($urandom_range(0, 99) < 35);
      if (is_event)
        push_item(OP_EVENT, ($urandom_range(0, 3) == 0), 1'($urandom));
      else
        push_ticks(1);
    end
  endtask

  // result side: random hold-off per result, plus one long stall on request
  initial begin
    int wait_cycles;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      wait_cycles = $urandom_range(0, gap_max);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_TICK;
    in_ch.reset_pressed <= 1'b0;
    in_ch.count_pressed <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_RESET_LOCKOUT;
    cfg_ch.data         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default lockouts: events before the first tick show a blank display,
    // and everything early is locked out
    push_item(OP_EVENT, 1'b1, 1'b1);
    push_item(OP_EVENT, 1'b0, 1'b0);
    push_ticks(5);
    push_item(OP_EVENT, 1'b0, 1'b1);
    push_item(OP_EVENT, 1'b1, 1'b0);
    settle();

    // zero lockouts, plus writes to unmapped indexes that must be dropped
    write_reg(CFG_RESET_LOCKOUT, '0);
    write_reg(CFG_COUNT_LOCKOUT, '0);
    write_reg(CFG_UNMAPPED_A, 16'hFFFF);
    write_reg(CFG_UNMAPPED_B, 16'h5A5A);
    push_ticks(1);
    push_item(OP_EVENT, 1'b0, 1'b1);
    push_item(OP_EVENT, 1'b0, 1'b1);  // same ms as last accept
    push_ticks(1);
    push_item(OP_EVENT, 1'b1, 1'b1);  // reset wins over count
    push_ticks(1);
    push_item(OP_EVENT, 1'b0, 1'b1);
    push_ticks(1);
    push_item(OP_EVENT, 1'b1, 1'b0);
    push_ticks(2);

    // count through the carries into the tens and hundreds digits
    gap_max = 0;
    push_ticks(1);
    push_item(OP_EVENT, 1'b1, 1'b0);
    for (int i = 0; i < COUNT_RUN; i++) begin
      push_ticks(1);
      push_item(OP_EVENT, 1'b0, 1'b1);
    end
    push_ticks(4);
    push_item(OP_EVENT, 1'b0, 1'b1);
    push_ticks(3);
    settle();

    // largest lockouts hold every press off
    write_reg(CFG_RESET_LOCKOUT, LOCK_W'(LOCK_MAX));
    write_reg(CFG_COUNT_LOCKOUT, LOCK_W'(LOCK_MAX));
    push_item(OP_EVENT, 1'b0, 1'b1);
    push_item(OP_EVENT, 1'b1, 1'b0);
    push_ticks(30);
    push_item(OP_EVENT, 1'b1, 1'b1);
    settle();

    // lockout boundary: exactly the lockout since the last accept is not enough
    gap_max = GAP_MAX;
    write_reg(CFG_RESET_LOCKOUT, LOCK_W'(BOUND_LOCK));
    write_reg(CFG_COUNT_LOCKOUT, LOCK_W'(BOUND_LOCK));
    push_ticks(BOUND_LOCK + 1);
    push_item(OP_EVENT, 1'b1, 1'b1);
    push_ticks(BOUND_LOCK);
    push_item(OP_EVENT, 1'b0, 1'b1);
    push_ticks(1);
    push_item(OP_EVENT, 1'b0, 1'b1);
    push_ticks(BOUND_LOCK);
    push_item(OP_EVENT, 1'b1, 1'b0);
    push_ticks(1);
    push_item(OP_EVENT, 1'b1, 1'b0);
    push_ticks(2);
    settle();

    // random phases under several lockout settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_RESET_LOCKOUT, LOCK_W'(3));
          write_reg(CFG_COUNT_LOCKOUT, '0);
        end
        1: begin
          write_reg(CFG_RESET_LOCKOUT, LOCK_W'($urandom_range(0, 15)));
          write_reg(CFG_COUNT_LOCKOUT, LOCK_W'($urandom_range(0, 15)));
        end
        2: begin
          write_reg(CFG_RESET_LOCKOUT, '0);
          write_reg(CFG_COUNT_LOCKOUT, LOCK_W'($urandom_range(0, 4)));
        end
        3: begin
          write_reg(CFG_RESET_LOCKOUT, LOCK_W'(200));
          write_reg(CFG_COUNT_LOCKOUT, LOCK_W'(40));
        end
        default: begin
          write_reg(CFG_RESET_LOCKOUT, LOCK_W'($urandom));
          write_reg(CFG_COUNT_LOCKOUT, LOCK_W'($urandom_range(0, 10)));
        end
      endcase
      if (ph == 1) begin
        // back-to-back requests against a stalled result side
        gap_max = 0;
        stall_req++;
        push_ticks(30);
      end
      random_items(260);
      settle();
    end

    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dcd_pkg.sv
rtl/dcd_channels.sv
rtl/dcd_digit_cell.sv
rtl/dcd_out_skid.sv
rtl/debounced_decimal_counter_display.sv
tb/sv/dcd_display_checker.sv
tb/sv/debounced_decimal_counter_display_tb.sv
